FILE: hw/rtl/feal_pkg.sv
package feal_pkg;

    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CIPHER_KEY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARITY_STRIP = 2'd1;

    localparam logic [63:0] KEY_PARITY_MASK = 64'hfefe_fefe_fefe_fefe;

    typedef logic [31:0] t_word;
    typedef logic [15:0] t_subkey;

    function automatic logic [7:0] sbox(input logic [7:0] x, input logic [7:0] y,
                                        input logic d);
        logic [7:0] s;
        s = x + y + {7'd0, d};
        return {s[5:0], s[7:6]};
    endfunction

    function automatic t_word key_fn(input t_word a, input t_word b);
        logic [7:0] t0;
        logic [7:0] t1;
        logic [7:0] t2;
        logic [7:0] t3;
        t1 = a[23:16] ^ a[31:24];
        t2 = a[15:8] ^ a[7:0];
        t1 = sbox(t1, t2 ^ b[31:24], 1'b1);
        t2 = sbox(t2, t1 ^ b[23:16], 1'b0);
        t0 = sbox(a[31:24], t1 ^ b[15:8], 1'b0);
        t3 = sbox(a[7:0], t2 ^ b[7:0], 1'b1);
        return {t0, t1, t2, t3};
    endfunction

    function automatic t_word round_fn(input t_word a, input t_subkey k);
        logic [7:0] t0;
        logic [7:0] t1;
        logic [7:0] t2;
        logic [7:0] t3;
        t1 = a[23:16] ^ k[15:8] ^ a[31:24];
        t2 = a[15:8] ^ k[7:0] ^ a[7:0];
        t1 = sbox(t1, t2, 1'b1);
        t2 = sbox(t2, t1, 1'b0);
        t0 = sbox(a[31:24], t1, 1'b0);
        t3 = sbox(a[7:0], t2, 1'b1);
        return {t0, t1, t2, t3};
    endfunction

endpackage

FILE: hw/rtl/feal_ram.sv
module feal_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/feal_block_cipher_unit.sv
// FEAL-N block cipher with a 64-bit key.
// Configuration: a write channel (i_cfg_valid / o_cfg_ready, always ready) sets the
// cipher key (index 0) and the parity strip bit (index 1); other indices are ignored.
// A write to either register marks the subkeys stale. Write only while the block is idle.
// Input: a beat on i_in_valid with o_in_stall low carries a mode bit and one block.
// The block then raises o_in_stall until the item has finished.
// Output: o_out_valid with o_data_out is held in an output register until a beat
// with i_out_stall low; a new item may be accepted while that result waits.
// Sequence: ST_PREP loads the block into the round registers, then ST_ROUND runs the
// rounds, one Feistel round per cycle through a shared round unit, and ST_FIN loads
// the output register.
// The first item after reset or after a key or parity write first runs the key
// schedule in ST_EXPAND, one subkey per cycle.
// Reset clears the control state and marks the subkeys stale; the key resets to zero.
// While the result register is full and stalled, a finished item waits in its last step.
module feal_block_cipher_unit #(
    parameter int unsigned ROUNDS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [feal_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [63:0]                     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_mode,
    input  logic [63:0]                     i_data_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [63:0]                     o_data_out
);

    import feal_pkg::*;

    localparam int unsigned KEY_STEPS   = (ROUNDS + 9) / 2;
    localparam int unsigned STORE_DEPTH = 2 * KEY_STEPS;
    localparam int unsigned KW          = $clog2(STORE_DEPTH);
    localparam int unsigned AW          = $clog2(ROUNDS);

    localparam logic [KW-1:0] ROUNDS_K   = KW'(ROUNDS);
    localparam logic [KW-1:0] KIDX_LAST  = KW'(STORE_DEPTH - 1);
    localparam logic [KW-1:0] WK_COUNT   = KW'(8);
    localparam logic [AW-1:0] ROUND_LAST = AW'(ROUNDS - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXPAND = 3'd1;
    localparam logic [2:0] ST_PREP   = 3'd2;
    localparam logic [2:0] ST_ROUND  = 3'd3;
    localparam logic [2:0] ST_FIN    = 3'd4;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [63:0]   r_key;
    logic          r_parity;
    logic          r_keys_valid;
    logic          r_mode;
    logic [63:0]   r_blk;
    t_word         r_x;
    t_word         n_x;
    t_word         r_y;
    t_word         n_y;
    logic [AW-1:0] r_cnt;
    logic [KW-1:0] r_kidx;
    t_word         r_ka;
    t_word         r_kb;
    t_word         r_kd;
    t_subkey       r_wk [8];
    logic          r_out_valid;
    logic [63:0]   r_data_out;

    logic          accept;
    logic [63:0]   key_eff;
    t_word         nb;
    t_subkey       exp_wdata;
    logic [KW-1:0] wk_off;
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    t_subkey       ram_rdata;
    t_word         w0;
    t_word         w2;
    t_word         w4;
    t_word         w6;
    logic          out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign accept      = i_in_valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;

    assign key_eff   = r_parity ? (r_key & KEY_PARITY_MASK) : r_key;
    assign nb        = key_fn(r_ka, r_kb ^ r_kd);
    assign exp_wdata = r_kidx[0] ? r_kb[15:0] : nb[31:16];
    assign wk_off    = r_kidx - ROUNDS_K;
    assign ram_we    = (r_state == ST_EXPAND) && (r_kidx < ROUNDS_K);

    assign w0 = {r_wk[0], r_wk[1]};
    assign w2 = {r_wk[2], r_wk[3]};
    assign w4 = {r_wk[4], r_wk[5]};
    assign w6 = {r_wk[6], r_wk[7]};

    always_comb begin
        if (r_state == ST_PREP) begin
            ram_raddr = r_mode ? ROUND_LAST : '0;
        end else begin
            ram_raddr = r_mode ? (ROUND_LAST - r_cnt - AW'(1)) : (r_cnt + AW'(1));
        end
    end

    feal_ram #(
        .WIDTH (16),
        .DEPTH (ROUNDS)
    ) u_subkeys (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_kidx[AW-1:0]),
        .i_wdata (exp_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (r_keys_valid) ? ST_PREP : ST_EXPAND;
                end
            end
            ST_EXPAND: begin
                if (r_kidx == KIDX_LAST) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                if (r_mode) begin
                    n_x = r_blk[63:32] ^ w4;
                    n_y = r_blk[31:0] ^ w6 ^ n_x;
                end else begin
                    n_x = r_blk[63:32] ^ w0;
                    n_y = r_blk[31:0] ^ w2 ^ n_x;
                end
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                n_x = r_y;
                n_y = r_x ^ round_fn(r_y, ram_rdata);
                if (r_cnt == ROUND_LAST) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_key        <= '0;
            r_parity     <= 1'b0;
            r_keys_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
            r_kidx       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_CIPHER_KEY) begin
                    r_key        <= i_cfg_data;
                    r_keys_valid <= 1'b0;
                end else if (i_cfg_index == REG_PARITY_STRIP) begin
                    r_parity     <= i_cfg_data[0];
                    r_keys_valid <= 1'b0;
                end
            end
            if (accept) begin
                r_kidx <= '0;
            end else if (r_state == ST_EXPAND) begin
                r_kidx <= r_kidx + KW'(1);
                if (r_kidx == KIDX_LAST) begin
                    r_keys_valid <= 1'b1;
                end
            end
            if (r_state == ST_PREP) begin
                r_cnt <= '0;
            end else if (r_state == ST_ROUND) begin
                r_cnt <= r_cnt + AW'(1);
            end
            if ((r_state == ST_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        if (accept) begin
            r_mode <= i_mode;
            r_blk  <= i_data_in;
            r_ka   <= key_eff[63:32];
            r_kb   <= key_eff[31:0];
            r_kd   <= '0;
        end else if ((r_state == ST_EXPAND) && !r_kidx[0]) begin
            r_kd <= r_ka;
            r_ka <= r_kb;
            r_kb <= nb;
        end
        if ((r_state == ST_EXPAND) && (r_kidx >= ROUNDS_K) && (wk_off < WK_COUNT)) begin
            r_wk[wk_off[2:0]] <= exp_wdata;
        end
        if ((r_state == ST_FIN) && out_free) begin
            if (r_mode) begin
                r_data_out <= {r_y ^ w0, r_x ^ r_y ^ w2};
            end else begin
                r_data_out <= {r_y ^ w4, r_x ^ r_y ^ w6};
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data_out;

endmodule
